@@ design/olpfd_pkg.sv @@
// shared types and constants for the ordered list block
package olpfd_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_DISPLAY = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_ELEMENT   = 3'd4
	} status_t;

	typedef struct packed {
		logic                    valid;
		status_t                 status;
		logic signed [VAL_W-1:0] element;
		logic                    last;
	} res_t;

endpackage

@@ design/olpfd_node_ram.sv @@
// node memory: one write port, one read port with registered read data
module olpfd_node_ram #(
	parameter int DEPTH = olpfd_pkg::DEPTH_DEF,
	parameter int AW    = 4,
	parameter int WIDTH = olpfd_pkg::VAL_W + 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/olpfd_out_reg.sv @@
// result output register on the master stream side
module olpfd_out_reg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  olpfd_pkg::res_t                      push,
	output logic                                 out_rdy,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [olpfd_pkg::VAL_W-1:0]          m_tdata,
	output logic [2:0]                           m_tuser,
	output logic                                 m_tlast
);

	logic                                valid_q;
	logic [olpfd_pkg::VAL_W-1:0]         data_q;
	olpfd_pkg::status_t                  status_q;
	logic                                last_q;

	assign out_rdy = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_rdy) begin
			valid_q <= push.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && push.valid) begin
			data_q   <= push.element;
			status_q <= push.status;
			last_q   <= push.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

endmodule

@@ design/olpfd_ctrl.sv @@
// list sequencer: allocation, walk, unlink and listing over the node memory
module olpfd_ctrl #(
	parameter int DEPTH = olpfd_pkg::DEPTH_DEF,
	parameter int AW    = 4,
	parameter int CW    = 5,
	parameter int WIDTH = olpfd_pkg::VAL_W + 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  olpfd_pkg::op_t                      in_op,
	input  logic [olpfd_pkg::VAL_W-1:0]         in_value,
	input  logic                                out_rdy,
	output olpfd_pkg::res_t                     push,
	output logic                                wr_en,
	output logic [AW-1:0]                       wr_addr,
	output logic [WIDTH-1:0]                    wr_data,
	output logic                                rd_en,
	output logic [AW-1:0]                       rd_addr,
	input  logic [WIDTH-1:0]                    rd_data,
	output logic [CW-1:0]                       count
);

	localparam int VW = olpfd_pkg::VAL_W;
	localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C  = CW'(1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ALLOC = 6'b000010,
		S_WALK  = 6'b000100,
		S_FREE  = 6'b001000,
		S_SHOW  = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	logic [AW-1:0]      head_q, head_d;
	logic [AW-1:0]      free_q, free_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      hwm_q, hwm_d;
	logic [CW-1:0]      rem_q, rem_d;
	logic [AW-1:0]      cur_q, cur_d;
	logic [AW-1:0]      prev_q, prev_d;
	logic [VW-1:0]      prev_val_q, prev_val_d;
	logic               first_q, first_d;
	logic [VW-1:0]      val_q, val_d;
	olpfd_pkg::status_t status_q, status_d;

	logic [VW-1:0]      rd_val;
	logic [AW-1:0]      rd_nxt;

	assign rd_val   = rd_data[VW-1:0];
	assign rd_nxt   = rd_data[WIDTH-1:VW];
	assign in_ready = (state_q == S_IDLE);
	assign count    = count_q;

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		free_d     = free_q;
		count_d    = count_q;
		hwm_d      = hwm_q;
		rem_d      = rem_q;
		cur_d      = cur_q;
		prev_d     = prev_q;
		prev_val_d = prev_val_q;
		first_d    = first_q;
		val_d      = val_q;
		status_d   = status_q;
		wr_en      = 1'b0;
		wr_addr    = cur_q;
		wr_data    = '0;
		rd_en      = 1'b0;
		rd_addr    = cur_q;
		push       = '0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					val_d = in_value;
					unique case (in_op)
						olpfd_pkg::OP_INSERT: begin
							if (count_q == FULL_C) begin
								status_d = olpfd_pkg::ST_FULL;
								state_d  = S_RESP;
							end else if (hwm_q != FULL_C) begin
								// never-used node, no read needed
								wr_en    = 1'b1;
								wr_addr  = hwm_q[AW-1:0];
								wr_data  = {head_q, in_value};
								head_d   = hwm_q[AW-1:0];
								hwm_d    = hwm_q + ONE_C;
								count_d  = count_q + ONE_C;
								status_d = olpfd_pkg::ST_DONE;
								state_d  = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = free_q;
								cur_d   = free_q;
								state_d = S_ALLOC;
							end
						end
						olpfd_pkg::OP_DELETE: begin
							if (count_q == '0) begin
								status_d = olpfd_pkg::ST_NOT_FOUND;
								state_d  = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q;
								cur_d   = head_q;
								first_d = 1'b1;
								rem_d   = count_q;
								state_d = S_WALK;
							end
						end
						olpfd_pkg::OP_DISPLAY: begin
							if (count_q == '0) begin
								status_d = olpfd_pkg::ST_EMPTY;
								state_d  = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q;
								cur_d   = head_q;
								rem_d   = count_q;
								state_d = S_SHOW;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_ALLOC: begin
				// pop the free list and link the node at the front
				free_d   = rd_nxt;
				wr_en    = 1'b1;
				wr_addr  = cur_q;
				wr_data  = {head_q, val_q};
				head_d   = cur_q;
				count_d  = count_q + ONE_C;
				status_d = olpfd_pkg::ST_DONE;
				state_d  = S_RESP;
			end
			S_WALK: begin
				if (rd_val == val_q) begin
					if (first_q) begin
						head_d = rd_nxt;
					end else begin
						wr_en   = 1'b1;
						wr_addr = prev_q;
						wr_data = {rd_nxt, prev_val_q};
					end
					count_d = count_q - ONE_C;
					state_d = S_FREE;
				end else if (rem_q == ONE_C) begin
					status_d = olpfd_pkg::ST_NOT_FOUND;
					state_d  = S_RESP;
				end else begin
					prev_d     = cur_q;
					prev_val_d = rd_val;
					first_d    = 1'b0;
					cur_d      = rd_nxt;
					rd_en      = 1'b1;
					rd_addr    = rd_nxt;
					rem_d      = rem_q - ONE_C;
				end
			end
			S_FREE: begin
				// push the unlinked node onto the free list
				wr_en    = 1'b1;
				wr_addr  = cur_q;
				wr_data  = {free_q, val_q};
				free_d   = cur_q;
				status_d = olpfd_pkg::ST_DONE;
				state_d  = S_RESP;
			end
			S_SHOW: begin
				if (out_rdy) begin
					push.valid   = 1'b1;
					push.status  = olpfd_pkg::ST_ELEMENT;
					push.element = rd_val;
					push.last    = (rem_q == ONE_C);
					if (rem_q == ONE_C) begin
						state_d = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = rd_nxt;
						cur_d   = rd_nxt;
						rem_d   = rem_q - ONE_C;
					end
				end
			end
			S_RESP: begin
				if (out_rdy) begin
					push.valid  = 1'b1;
					push.status = status_q;
					push.last   = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			free_q  <= '0;
			count_q <= '0;
			hwm_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			count_q <= count_d;
			hwm_q   <= hwm_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q      <= rem_d;
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		prev_val_q <= prev_val_d;
		first_q    <= first_d;
		val_q      <= val_d;
		status_q   <= status_d;
	end

endmodule

@@ design/ordered_list_push_front_delete.sv @@
// Ordered list of up to DEPTH signed 32-bit values, held as a singly linked list of
// nodes {next, value} in one synchronous node memory with registered read data.
// Operations are handled one at a time. An insert of a never-used node writes it
// straight from idle; a node taken back from the free list is first read, then
// written; either way its status is then handed over. A delete walks the list one
// node per cycle through the single read port before its status. A display lists
// one entry per cycle while the output accepts it, from front to back, with tlast on
// the final one. Nodes need no clearing after reset: the list is usable at once.
module ordered_list_push_front_delete #(
	parameter int DEPTH = olpfd_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value
	input  logic [1:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // element
	output logic [2:0]  m_tuser,   // status
	output logic        m_tlast
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int WIDTH = olpfd_pkg::VAL_W + AW;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [WIDTH-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [WIDTH-1:0] rd_data;
	logic             out_rdy;
	olpfd_pkg::res_t  push;
	logic [CW-1:0]    count;

	olpfd_node_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.WIDTH (WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	olpfd_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW),
		.WIDTH (WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (olpfd_pkg::op_t'(s_tuser)),
		.in_value (s_tdata),
		.out_rdy  (out_rdy),
		.push     (push),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.count    (count)
	);

	olpfd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.out_rdy  (out_rdy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(DEPTH))
		else $error("list count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count != $past(count) |-> (count == $past(count) + CW'(1)) ||
			(count == $past(count) - CW'(1)))
		else $error("list count moved by more than one");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != olpfd_pkg::ST_ELEMENT) |-> m_tlast)
		else $error("status transfer without tlast");

endmodule
